// ===== rtl/core/hmr_pkg.sv =====
// Package for the HID message reassembler: report layout positions and the
// result record type. No dependencies.
`default_nettype none

package hmr_pkg;

  // Report layout: channel id bytes, then command or sequence, then length.
  localparam logic [6:0] ID_BYTES         = 7'd4;
  localparam logic [6:0] CMD_POS          = 7'd4;
  localparam logic [6:0] LEN_HI_POS       = 7'd5;
  localparam logic [6:0] LEN_LO_POS       = 7'd6;
  localparam logic [6:0] INIT_PAY_START   = 7'd7;
  localparam logic [6:0] CONT_PAY_START   = 7'd5;
  localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;
  localparam logic [6:0] RESET_REPORT     = 7'd64;

  // One result record as held in the output register.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [12:0] byte_offset;
    logic        byte_valid;
    logic        msg_done;
    logic [15:0] msg_length;
    logic [31:0] channel_id;
    logic [7:0]  command;
    logic        oversize;
  } hmr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hid_message_reassembler.sv =====
// HID message reassembler top level: takes report bytes, emits payload bytes
// with offsets and message completions. Depends on hmr_pkg.
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_rx_byte
// out_      output     out_valid/out_stall payload byte, offset, completion info
// cfg_      input      cfg_we             cfg_wdata (report size in bytes)
//
// A new byte can be accepted every cycle while the input is not stalled.
// The result appears in the output register on the cycle after acceptance.
// Input stalls only while the output register holds a result that is stalled.
// Reset is synchronous, active low, and clears all reassembly state.
// The report size resets to 64 bytes.

module hid_message_reassembler #(
  parameter int MAX_MESSAGE = 8192,
  parameter int MAX_REPORT  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic [12:0]      out_byte_offset,
  output logic             out_byte_valid,
  output logic             out_msg_done,
  output logic [15:0]      out_msg_length,
  output logic [31:0]      out_channel_id,
  output logic [7:0]       out_command,
  output logic             out_oversize,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);
  import hmr_pkg::*;

  localparam logic [16:0] MaxMsg = 17'(MAX_MESSAGE);
  localparam logic [6:0]  MaxRep = 7'(MAX_REPORT);

  logic [6:0]  report_bytes_r;
  logic [6:0]  report_index_r, report_index_nxt;
  logic [31:0] id_shift_r, id_shift_nxt;
  logic        is_init_r, is_init_nxt;
  logic [7:0]  len_high_r, len_high_nxt;
  logic [15:0] msg_len_r, msg_len_nxt;
  logic [15:0] rcvd_r, rcvd_nxt;
  logic        open_r, open_nxt;
  logic [31:0] held_chan_r, held_chan_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic        out_valid_r, out_valid_nxt;
  hmr_result_t out_r, out_nxt;

  logic        in_acc;
  logic [6:0]  rep_eff;
  logic        last_byte;
  logic [6:0]  first_pay;
  logic        emit_byte;
  logic [12:0] emit_off;
  logic        done_c;

  // Input is held off only while a finished result waits on a stalled output.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Effective report size, clamped to the supported range.
  always_comb begin
    rep_eff = report_bytes_r;
    if (rep_eff < MIN_REPORT_BYTES) rep_eff = MIN_REPORT_BYTES;
    if (rep_eff > MaxRep) rep_eff = MaxRep;
    last_byte = report_index_r >= (rep_eff - 7'd1);
  end

  // Per-byte parse: header fields, payload counting and completion.
  always_comb begin
    report_index_nxt = report_index_r;
    id_shift_nxt     = id_shift_r;
    is_init_nxt      = is_init_r;
    len_high_nxt     = len_high_r;
    msg_len_nxt      = msg_len_r;
    rcvd_nxt         = rcvd_r;
    open_nxt         = open_r;
    held_chan_nxt    = held_chan_r;
    held_cmd_nxt     = held_cmd_r;
    first_pay        = CONT_PAY_START;
    emit_byte        = 1'b0;
    emit_off         = '0;
    done_c           = 1'b0;
    if (in_acc) begin
      if (report_index_r < ID_BYTES) begin
        id_shift_nxt = {id_shift_r[23:0], in_rx_byte};
      end else if (report_index_r == CMD_POS) begin
        is_init_nxt = in_rx_byte[7];
        if (in_rx_byte[7]) begin
          held_chan_nxt = id_shift_r;
          held_cmd_nxt  = in_rx_byte;
          open_nxt      = 1'b0;
          rcvd_nxt      = '0;
        end
      end else if (report_index_r == LEN_HI_POS && is_init_r) begin
        len_high_nxt = in_rx_byte;
      end else if (report_index_r == LEN_LO_POS && is_init_r) begin
        msg_len_nxt = {len_high_r, in_rx_byte};
        rcvd_nxt    = '0;
        open_nxt    = 1'b1;
      end

      // Payload bytes count while the open message still owes bytes.
      first_pay = is_init_nxt ? INIT_PAY_START : CONT_PAY_START;
      if (report_index_r >= first_pay && open_nxt && rcvd_nxt < msg_len_nxt) begin
        emit_byte = {1'b0, rcvd_nxt} < MaxMsg;
        emit_off  = rcvd_nxt[12:0];
        rcvd_nxt  = rcvd_nxt + 16'd1;
      end

      // At report end, close a message whose bytes have all arrived.
      if (last_byte) begin
        if (open_nxt && rcvd_nxt == msg_len_nxt) begin
          done_c   = 1'b1;
          open_nxt = 1'b0;
        end
        report_index_nxt = '0;
      end else begin
        report_index_nxt = report_index_r + 7'd1;
      end
    end
  end

  // Result register: load on a producing byte, drain when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (in_acc && (emit_byte || done_c)) begin
      out_valid_nxt        = 1'b1;
      out_nxt.payload_byte = emit_byte ? in_rx_byte : 8'd0;
      out_nxt.byte_offset  = emit_byte ? emit_off : 13'd0;
      out_nxt.byte_valid   = emit_byte;
      out_nxt.msg_done     = done_c;
      out_nxt.msg_length   = done_c ? msg_len_nxt : 16'd0;
      out_nxt.channel_id   = done_c ? held_chan_nxt : 32'd0;
      out_nxt.command      = done_c ? held_cmd_nxt : 8'd0;
      out_nxt.oversize     = done_c && ({1'b0, msg_len_nxt} > MaxMsg);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and reassembly state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_bytes_r <= RESET_REPORT;
      report_index_r <= '0;
      id_shift_r     <= '0;
      is_init_r      <= 1'b0;
      len_high_r     <= '0;
      msg_len_r      <= '0;
      rcvd_r         <= '0;
      open_r         <= 1'b0;
      held_chan_r    <= '0;
      held_cmd_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) report_bytes_r <= cfg_wdata;
      report_index_r <= report_index_nxt;
      id_shift_r     <= id_shift_nxt;
      is_init_r      <= is_init_nxt;
      len_high_r     <= len_high_nxt;
      msg_len_r      <= msg_len_nxt;
      rcvd_r         <= rcvd_nxt;
      open_r         <= open_nxt;
      held_chan_r    <= held_chan_nxt;
      held_cmd_r     <= held_cmd_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_offset  = out_r.byte_offset;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_msg_done     = out_r.msg_done;
  assign out_msg_length   = out_r.msg_length;
  assign out_channel_id   = out_r.channel_id;
  assign out_command      = out_r.command;
  assign out_oversize     = out_r.oversize;

  // A completion always closes the message.
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done_c) |=> !open_r)
    else $error("message still open after completion");

  // A held result always carries a byte or a completion.
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.byte_valid || out_r.msg_done))
    else $error("empty result held in output register");

  // The byte position never runs past the largest report.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    report_index_r < MaxRep)
    else $error("report index out of range");

  // A stalled result is never overwritten by a new request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_r) && out_valid_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== verif/hmr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the HID message reassembler testbench: a predictor of the
// reassembly state and the queue of awaited result records. Depends on hmr_pkg.

package hmr_tb_pkg;

  import hmr_pkg::*;

  localparam int unsigned MESSAGE_BOUND = 8192;
  localparam int unsigned REPORT_BOUND  = 64;

  class reassembly_scoreboard;

    // Register copy and reassembly state, at the widths of the block.
    logic [6:0]  report_size;
    logic [6:0]  byte_pos;
    logic [31:0] id_shift;
    logic        init_report;
    logic [7:0]  len_upper;
    logic [15:0] declared_len;
    logic [15:0] bytes_taken;
    logic        msg_open;
    logic [31:0] saved_channel;
    logic [7:0]  saved_command;

    hmr_result_t awaited_records[$];
    int          error_count;
    int          records_seen;

    function new();
      report_size   = RESET_REPORT;
      byte_pos      = '0;
      id_shift      = '0;
      init_report   = 1'b0;
      len_upper     = '0;
      declared_len  = '0;
      bytes_taken   = '0;
      msg_open      = 1'b0;
      saved_channel = '0;
      saved_command = '0;
      error_count   = 0;
      records_seen  = 0;
    endfunction

    function void set_report_size(logic [6:0] value);
      report_size = value;
    endfunction

    // The register is clamped to the range the block supports.
    function int unsigned effective_size();
      if (report_size < MIN_REPORT_BYTES) begin
        return MIN_REPORT_BYTES;
      end
      if (report_size > REPORT_BOUND) begin
        return REPORT_BOUND;
      end
      return report_size;
    endfunction

    function bit at_report_start();
      return byte_pos == '0;
    endfunction

    function int pending();
      return awaited_records.size();
    endfunction

    // Advances the reassembly state by one accepted request and queues the
    // record it causes, if any.
    function void take_report_byte(logic [7:0] value);
      int unsigned size;
      logic        last_byte;
      logic [6:0]  payload_start;
      hmr_result_t rec;
      size      = effective_size();
      last_byte = (byte_pos >= size - 1);
      rec       = '0;

      // Header fields: channel id, command or sequence, declared length.
      if (byte_pos < ID_BYTES) begin
        id_shift = {id_shift[23:0], value};
      end else if (byte_pos == CMD_POS) begin
        init_report = value[7];
        if (init_report) begin
          saved_channel = id_shift;
          saved_command = value;
          msg_open      = 1'b0;
          bytes_taken   = '0;
        end
      end else if (byte_pos == LEN_HI_POS && init_report) begin
        len_upper = value;
      end else if (byte_pos == LEN_LO_POS && init_report) begin
        declared_len = {len_upper, value};
        bytes_taken  = '0;
        msg_open     = 1'b1;
      end

      // Payload bytes are taken only while bytes are still owed; bytes past
      // the buffer bound are counted but not written.
      payload_start = init_report ? INIT_PAY_START : CONT_PAY_START;
      if (byte_pos >= payload_start && msg_open && bytes_taken < declared_len) begin
        if (bytes_taken < MESSAGE_BOUND) begin
          rec.payload_byte = value;
          rec.byte_offset  = bytes_taken[12:0];
          rec.byte_valid   = 1'b1;
        end
        bytes_taken = bytes_taken + 16'd1;
      end

      // The message completes on the last byte of a report.
      if (last_byte) begin
        if (msg_open && bytes_taken == declared_len) begin
          rec.msg_done   = 1'b1;
          rec.msg_length = declared_len;
          rec.channel_id = saved_channel;
          rec.command    = saved_command;
          rec.oversize   = (declared_len > MESSAGE_BOUND);
          msg_open       = 1'b0;
        end
        byte_pos = '0;
      end else begin
        byte_pos = byte_pos + 7'd1;
      end

      if (rec.byte_valid || rec.msg_done) begin
        awaited_records.push_back(rec);
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) begin
        report($sformatf("%s is %0h, %0h awaited", name, got, want));
      end
    endtask

    // Compares one accepted record with the oldest awaited one.
    task check_record(hmr_result_t got);
      hmr_result_t want;
      if (awaited_records.size() == 0) begin
        report($sformatf("record %p arrived with none awaited", got));
      end else begin
        want = awaited_records.pop_front();
        compare_field("payload_byte", got.payload_byte, want.payload_byte);
        compare_field("byte_offset", got.byte_offset, want.byte_offset);
        compare_field("byte_valid", got.byte_valid, want.byte_valid);
        compare_field("msg_done", got.msg_done, want.msg_done);
        compare_field("msg_length", got.msg_length, want.msg_length);
        compare_field("channel_id", got.channel_id, want.channel_id);
        compare_field("command", got.command, want.command);
        compare_field("oversize", got.oversize, want.oversize);
      end
      records_seen++;
    endtask

  endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top testbench for the HID message reassembler: drives report byte streams
// and checks every record. Depends on hmr_pkg and hmr_tb_pkg.

module testbench;

  import hmr_pkg::*;
  import hmr_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 20;
  localparam int HOLD_CYCLES   = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  out_payload_byte;
  logic [12:0] out_byte_offset;
  logic        out_byte_valid;
  logic        out_msg_done;
  logic [15:0] out_msg_length;
  logic [31:0] out_channel_id;
  logic [7:0]  out_command;
  logic        out_oversize;
  logic        cfg_we     = 1'b0;
  logic [6:0]  cfg_wdata  = 7'd0;

  int          cycle_count = 0;
  logic        calm;
  int          hold_left = 0;
  int          holds_started = 0;
  int          phase_items = 0;
  logic [6:0]  phase_sizes [8];

  reassembly_scoreboard sb;

  hid_message_reassembler #(
    .MAX_MESSAGE(MESSAGE_BOUND),
    .MAX_REPORT (REPORT_BOUND)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_byte_offset (out_byte_offset),
    .out_byte_valid  (out_byte_valid),
    .out_msg_done    (out_msg_done),
    .out_msg_length  (out_msg_length),
    .out_channel_id  (out_channel_id),
    .out_command     (out_command),
    .out_oversize    (out_oversize),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Periodic stretches in which neither side idles at random.
  assign calm = ((cycle_count / 300) % 5) == 2;

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver: checks accepted records, stalls at random, and now and then
  // holds off for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_record('{out_payload_byte, out_byte_offset, out_byte_valid, out_msg_done,
                        out_msg_length, out_channel_id, out_command, out_oversize});
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end else if ((holds_started == 0 && sb.records_seen >= 100) ||
                 (holds_started == 1 && sb.records_seen >= 5000)) begin
      hold_left     = HOLD_CYCLES;
      holds_started = holds_started + 1;
    end
    out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 11);
  end

  // Offers one request and waits until the block takes it.
  task automatic send_request(input logic [7:0] value);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    sb.take_report_byte(value);
  endtask

  // Sends one whole report at the current size with the given header.
  task automatic send_report(input logic [31:0] chan, input logic [7:0] tag,
                             input logic [15:0] len_field);
    int unsigned size;
    size = sb.effective_size();
    for (int unsigned i = 0; i < size; i++) begin
      if (i < ID_BYTES) begin
        send_request(chan[8 * (3 - i) +: 8]);
      end else if (i == CMD_POS) begin
        send_request(tag);
      end else if (i == LEN_HI_POS) begin
        send_request(len_field[15:8]);
      end else if (i == LEN_LO_POS) begin
        send_request(len_field[7:0]);
      end else begin
        send_request(8'($urandom));
      end
    end
  endtask

  function automatic logic [7:0] sequence_tag();
    return {1'b0, 7'($urandom)};
  endfunction

  // An init report followed by just enough continuation reports.
  task automatic send_whole_message(input int unsigned len);
    int unsigned size;
    int unsigned conts;
    logic [31:0] chan;
    size  = sb.effective_size();
    chan  = $urandom;
    conts = (len > size - 7) ? (len - (size - 7) + (size - 5) - 1) / (size - 5) : 0;
    send_report(chan, {1'b1, 7'($urandom)}, 16'(len));
    repeat (conts) send_report(chan, sequence_tag(), 16'($urandom));
    phase_items += size * (1 + conts);
  endtask

  // Mostly well-formed messages; the rest are abandoned messages, noise
  // reports and stray continuation reports.
  task automatic send_message();
    int unsigned size;
    int unsigned roll;
    int unsigned len;
    size = sb.effective_size();
    roll = $urandom_range(99);
    if (roll < 70) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(0, (size - 7) + 3 * (size - 5));
      end else begin
        len = $urandom_range(0, (size - 7) + (size - 5));
      end
      send_whole_message(len);
      // A report after completion finds the message closed.
      if ($urandom_range(9) == 0) begin
        send_report($urandom, sequence_tag(), 16'($urandom));
      end
    end else if (roll < 80) begin
      // The next init report abandons this one.
      send_report($urandom, {1'b1, 7'($urandom)}, 16'($urandom));
      if ($urandom_range(1) == 1) begin
        send_report($urandom, sequence_tag(), 16'($urandom));
      end
      phase_items += size;
    end else if (roll < 90) begin
      repeat (size) send_request(8'($urandom));
    end else begin
      send_report($urandom, sequence_tag(), 16'($urandom));
    end
  endtask

  // Pauses the sender until every awaited record has come, then lets the
  // pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_size(input logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_report_size(value);
  endtask

  initial begin
    sb = new();
    phase_sizes = '{7'd7, 7'd127, 7'd8, 7'd20, 7'd65, 7'd12, 7'd0, 7'd64};
    phase_sizes[6] = 7'($urandom_range(9, 63));
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 7'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a size below the minimum, a one-byte message, a stray
    // continuation after completion, and a zero-length message.
    write_report_size(7'd0);
    send_report(32'h0000_0000, 8'h80, 16'd1);
    send_report(32'hFFFF_FFFF, 8'h7F, 16'hFFFF);
    send_report(32'hFFFF_FFFF, 8'hFF, 16'h0000);
    drain_results();

    // Random phases, each at its own report size. Some end mid-report, so
    // the next size takes effect part way through a report.
    for (int p = 0; p < 8; p++) begin
      write_report_size(phase_sizes[p]);
      while (!sb.at_report_start()) begin
        send_request(8'($urandom));
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_message();
        if ($urandom_range(19) == 0) begin
          drain_results();
        end
      end
      if (p % 2 == 1) begin
        repeat ($urandom_range(1, sb.effective_size() - 1)) send_request(8'($urandom));
      end
      drain_results();
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
